// ===== rtl/dsmrm_pkg.sv =====
// shared types and constants for the 3x3 regularity mask block
// no dependencies; imported by dsmrm_score and the top level of the block
package dsmrm_pkg;

    localparam int SMP_W        = 32;
    localparam int ROW_W        = 16;
    localparam int OCOL_W       = 12;
    localparam int THR_W        = 24;
    localparam int WID_W        = 13;
    localparam int NBR_N        = 8;
    localparam int CNT_W        = 4;
    localparam int PROD_W       = THR_W + CNT_W;
    localparam int SUM_W        = SMP_W + 3;
    localparam int FIFO_DEPTH   = 8;
    localparam int MAX_COLS_DEF = 4096;
    localparam int APB_AW       = 4;

    localparam logic [WID_W-1:0] RST_WIDTH  = 13'd4096;
    localparam logic [ROW_W-1:0] RST_HEIGHT = 16'd3;
    localparam logic [THR_W-1:0] RST_THRESH = 24'd256;
    localparam logic [SMP_W-1:0] RST_NODATA = 32'hFF80_0000;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [1:0] REG_NODATA = 2'd3;

    typedef logic signed [SMP_W-1:0] t_nbr_arr [NBR_N];

    typedef struct packed {
        logic [OCOL_W-1:0] col;
        logic [ROW_W-1:0]  row;
    } t_tag;

    typedef struct packed {
        logic              valid;
        logic              regular;
        t_tag              tag;
    } t_score_out;

    typedef struct packed {
        logic [OCOL_W-1:0] col;
        logic [ROW_W-1:0]  row;
        logic              regular;
    } t_result;

endpackage

// ===== rtl/dsmrm_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module dsmrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dsmrm_score.sv =====
// neighborhood difference scoring pipeline: abs diffs, adder tree, threshold compare
// depends on dsmrm_pkg
module dsmrm_score
    import dsmrm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_tag                    i_tag,
    input  logic signed [SMP_W-1:0] i_centre,
    input  t_nbr_arr                i_nbr,
    input  logic signed [SMP_W-1:0] i_nodata,
    input  logic [THR_W-1:0]        i_thresh,
    output t_score_out              o_out,
    output logic [1:0]              o_pending
);

    logic              r_a_vld, r_b_vld, r_c_vld;
    t_tag              r_a_tag, r_b_tag, r_c_tag;
    logic [SMP_W-1:0]  r_a_diff [NBR_N];
    logic [NBR_N-1:0]  r_a_use;
    logic [SMP_W:0]    r_b_pair [NBR_N/2];
    logic [CNT_W-1:0]  r_b_cnt;
    logic [SMP_W+1:0]  r_c_sum [2];
    logic [PROD_W-1:0] r_c_prod;

    logic [SMP_W-1:0]  n_a_diff [NBR_N];
    logic [NBR_N-1:0]  n_a_use;
    logic [SUM_W-1:0]  total;
    logic              centre_ok;

    always_comb begin
        logic signed [SMP_W:0] d;
        logic [SMP_W:0]        mag;
        centre_ok = i_centre > i_nodata;
        for (int k = 0; k < NBR_N; k++) begin
            d = {i_nbr[k][SMP_W-1], i_nbr[k]} - {i_centre[SMP_W-1], i_centre};
            mag = d[SMP_W] ? 33'(-d) : 33'(d);
            n_a_use[k] = centre_ok && (i_nbr[k] > i_nodata);
            n_a_diff[k] = n_a_use[k] ? mag[SMP_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_tag  <= i_tag;
        r_a_diff <= n_a_diff;
        r_a_use  <= n_a_use;

        r_b_tag <= r_a_tag;
        for (int j = 0; j < NBR_N / 2; j++) begin
            r_b_pair[j] <= {1'b0, r_a_diff[2*j]} + {1'b0, r_a_diff[2*j+1]};
        end
        r_b_cnt <= CNT_W'($countones(r_a_use));

        r_c_tag    <= r_b_tag;
        r_c_sum[0] <= {1'b0, r_b_pair[0]} + {1'b0, r_b_pair[1]};
        r_c_sum[1] <= {1'b0, r_b_pair[2]} + {1'b0, r_b_pair[3]};
        r_c_prod   <= PROD_W'(r_b_cnt) * PROD_W'(i_thresh);
    end

    assign total = {1'b0, r_c_sum[0]} + {1'b0, r_c_sum[1]};

    assign o_out.valid   = r_c_vld;
    assign o_out.regular = total < SUM_W'(r_c_prod);
    assign o_out.tag     = r_c_tag;
    assign o_pending     = 2'({1'b0, r_a_vld} + {1'b0, r_b_vld} + {1'b0, r_c_vld});

endmodule

// ===== rtl/dsm_regular_mask_3x3.sv =====
// top level of the 3x3 neighborhood regularity mask: apb registers, line stores,
// window, result fifo; depends on dsmrm_pkg, dsmrm_ram, dsmrm_score
//
// channel   dir  fields (lsb first)                      transfer when
// s_axis    in   tdata: elevation[31:0]                  tvalid & tready
// m_axis    out  tdata: is_regular, pixel_row, pixel_col tvalid & tready
// apb       in   regs 0..3 at 4*i                        psel & penable & pwrite
//
// one sample per clock sustained while tready is high; the line stores are read on transfer
// and written back in the next cycle, so each stored column is touched once per item
// results pass from stage one through the scoring pipeline into an 8-entry fifo
// input tready drops only when the fifo plus in-flight results would exceed 8
// synchronous active-low reset clears counters, window, fifo and registers;
// line store contents are undefined until a first row has been written
module dsm_regular_mask_3x3
    import dsmrm_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // elevation[31:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // is_regular[0], pixel_row[16:1], pixel_col[28:17]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WID_W-1:0]        r_width;
    logic [ROW_W-1:0]        r_height;
    logic [THR_W-1:0]        r_thresh;
    logic signed [SMP_W-1:0] r_nodata;

    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    logic                    r_s1_vld;
    logic                    r_s1_emit;
    logic [COL_W-1:0]        r_s1_col;
    t_tag                    r_s1_tag;
    logic signed [SMP_W-1:0] r_s1_smp;
    logic signed [SMP_W-1:0] r_win [6];

    t_result                 r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]        r_wr_ptr, r_rd_ptr;
    logic [FCNT_W-1:0]       r_count;

    logic                    in_acc, cfg_wr, push, pop, emit;
    logic [31:0]             width_eff, height_eff;
    logic [SMP_W-1:0]        top_new, mid_new;
    t_nbr_arr                nbr;
    t_score_out              score;
    logic [1:0]              pending;
    logic [FCNT_W+1:0]       occupancy;
    logic [31:0]             col_m1, row_m1;
    t_result                 head;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_thresh <= RST_THRESH;
            r_nodata <= RST_NODATA;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[WID_W-1:0];
                REG_HEIGHT: r_height <= pwdata[ROW_W-1:0];
                REG_THRESH: r_thresh <= pwdata[THR_W-1:0];
                REG_NODATA: r_nodata <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_THRESH: prdata = 32'(r_thresh);
            REG_NODATA: prdata = r_nodata;
        endcase
    end

    // raster position
    always_comb begin
        if (32'(r_width) < 32'd3) begin
            width_eff = 32'd3;
        end else if (32'(r_width) > 32'(MAX_COLUMNS)) begin
            width_eff = 32'(MAX_COLUMNS);
        end else begin
            width_eff = 32'(r_width);
        end
        height_eff = (r_height < 16'd3) ? 32'd3 : 32'(r_height);
    end

    assign occupancy     = (FCNT_W+2)'(r_count) + (FCNT_W+2)'(pending)
                         + (FCNT_W+2)'(r_s1_vld && r_s1_emit);
    assign s_axis_tready = occupancy < (FCNT_W+2)'(FIFO_DEPTH);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign emit          = (r_row >= 16'd2) && (32'(r_col) >= 32'd2);
    assign col_m1        = 32'(r_col) - 32'd1;
    assign row_m1        = 32'(r_row) - 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_acc;
            if (in_acc) begin
                if (32'(r_col) + 32'd1 >= width_eff) begin
                    r_col <= '0;
                    if (32'(r_row) + 32'd1 >= height_eff) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + 16'd1;
                    end
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_smp     <= s_axis_tdata;
            r_s1_col     <= r_col;
            r_s1_emit    <= emit;
            r_s1_tag.row <= row_m1[ROW_W-1:0];
            r_s1_tag.col <= col_m1[OCOL_W-1:0];
        end
    end

    // line stores: read at the counter, written back from stage one
    dsmrm_ram #(.WIDTH(SMP_W), .DEPTH(MAX_COLUMNS)) u_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_col),
        .i_wdata (mid_new),
        .i_raddr (r_col),
        .o_rdata (top_new)
    );

    dsmrm_ram #(.WIDTH(SMP_W), .DEPTH(MAX_COLUMNS)) u_middle (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_smp),
        .i_raddr (r_col),
        .o_rdata (mid_new)
    );

    // window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_vld) begin
            r_win[0] <= r_win[1];
            r_win[1] <= top_new;
            r_win[2] <= r_win[3];
            r_win[3] <= mid_new;
            r_win[4] <= r_win[5];
            r_win[5] <= r_s1_smp;
        end
    end

    assign nbr[0] = r_win[0];
    assign nbr[1] = r_win[1];
    assign nbr[2] = top_new;
    assign nbr[3] = r_win[2];
    assign nbr[4] = mid_new;
    assign nbr[5] = r_win[4];
    assign nbr[6] = r_win[5];
    assign nbr[7] = r_s1_smp;

    dsmrm_score u_score (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_vld && r_s1_emit),
        .i_tag     (r_s1_tag),
        .i_centre  (r_win[3]),
        .i_nbr     (nbr),
        .i_nodata  (r_nodata),
        .i_thresh  (r_thresh),
        .o_out     (score),
        .o_pending (pending)
    );

    // result fifo
    assign push = score.valid;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + FCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - FCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= '{col: score.tag.col, row: score.tag.row,
                                  regular: score.regular};
        end
    end

    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = r_count != '0;
    assign m_axis_tdata  = {3'b000, head.col, head.row, head.regular};

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_count < FCNT_W'(FIFO_DEPTH)))
        else $error("result fifo overflow");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= (FCNT_W+2)'(FIFO_DEPTH))
        else $error("in-flight results exceed fifo space");

    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        score.valid |-> (score.tag.row != '0) && ($past(r_s1_vld, 3) == 1'b1))
        else $error("result without an interior window");

endmodule

// ===== dv/tb_dsm_regular_mask_3x3.sv =====
// self-checking testbench for dsm_regular_mask_3x3: streams elevation rasters through the
// block, predicts each interior-pixel flag in a scoreboard class, checks every output transfer
// depends on dsmrm_pkg and the rtl of dsm_regular_mask_3x3
`timescale 1ns / 100ps

module tb_dsm_regular_mask_3x3
    import dsmrm_pkg::*;
();

    localparam logic [31:0] ELEV_MIN      = 32'h8000_0000;
    localparam logic [31:0] ELEV_MIN_P1   = 32'h8000_0001;
    localparam logic [31:0] ELEV_MAX      = 32'h7FFF_FFFF;
    localparam longint      ELEV_LO       = -64'sd2147483648;
    localparam longint      ELEV_HI       = 64'sd2147483647;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          MAX_REPORTS   = 200;

    class mask_checker;
        logic [WID_W-1:0]        width_reg;
        logic [ROW_W-1:0]        height_reg;
        logic [THR_W-1:0]        thresh_reg;
        logic signed [SMP_W-1:0] nodata_reg;
        logic [SMP_W-1:0]        upper_line [MAX_COLS_DEF];
        logic [SMP_W-1:0]        middle_line [MAX_COLS_DEF];
        logic [SMP_W-1:0]        win [6];
        int unsigned             col;
        int unsigned             row;
        t_result                 pending_pixels [$];
        int                      mismatches;

        function new();
            mismatches = 0;
            reset_state();
        endfunction

        function void reset_state();
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            thresh_reg = RST_THRESH;
            nodata_reg = RST_NODATA;
            foreach (upper_line[k]) upper_line[k] = '0;
            foreach (middle_line[k]) middle_line[k] = '0;
            foreach (win[k]) win[k] = '0;
            col = 0;
            row = 0;
            pending_pixels.delete();
        endfunction

        task flag_mismatch(string msg);
            if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_WIDTH:  width_reg  = val[WID_W-1:0];
                REG_HEIGHT: height_reg = val[ROW_W-1:0];
                REG_THRESH: thresh_reg = val[THR_W-1:0];
                REG_NODATA: nodata_reg = val;
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_WIDTH:  return 32'(width_reg);
                REG_HEIGHT: return 32'(height_reg);
                REG_THRESH: return 32'(thresh_reg);
                REG_NODATA: return nodata_reg;
                default:    return '0;
            endcase
        endfunction

        function bit frame_start();
            return (col == 0) && (row == 0);
        endfunction

        // one accepted sample: predict the flag of the pixel whose window it closes
        function void take_sample(logic [31:0] smp);
            int unsigned       w;
            int unsigned       h;
            int unsigned       c;
            logic [31:0]       top_new;
            logic [31:0]       mid_new;
            logic [31:0]       nbr [8];
            longint            nd;
            longint            ctr;
            longint            v;
            longint            diff;
            longint unsigned   total;
            longint unsigned   limit;
            int unsigned       n_ok;
            t_result           px;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > MAX_COLS_DEF) w = MAX_COLS_DEF;
            h = height_reg;
            if (h < 3) h = 3;
            c = col;
            if (c >= MAX_COLS_DEF) c = MAX_COLS_DEF - 1;
            top_new = upper_line[c];
            mid_new = middle_line[c];
            if (row >= 2 && c >= 2) begin
                nd    = longint'(nodata_reg);
                ctr   = longint'($signed(win[3]));
                total = 0;
                n_ok  = 0;
                if (ctr > nd) begin
                    nbr = '{win[0], win[1], top_new, win[2], mid_new, win[4], win[5], smp};
                    foreach (nbr[k]) begin
                        v = longint'($signed(nbr[k]));
                        if (v > nd) begin
                            diff = v - ctr;
                            total += longint'(diff < 0 ? -diff : diff);
                            n_ok++;
                        end
                    end
                end
                limit      = longint'(n_ok) * longint'(thresh_reg);
                px.regular = (total < limit);
                px.row     = 16'(row - 1);
                px.col     = 12'(c - 1);
                pending_pixels.push_back(px);
            end
            win[0] = win[1];
            win[1] = top_new;
            win[2] = win[3];
            win[3] = mid_new;
            win[4] = win[5];
            win[5] = smp;
            upper_line[c]  = mid_new;
            middle_line[c] = smp;
            if (c + 1 >= w) begin
                col = 0;
                if (row + 1 >= h) row = 0;
                else row = row + 1;
            end else begin
                col = c + 1;
            end
        endfunction

        task check_pixel(logic [31:0] tdata);
            t_result got;
            t_result want;
            got = tdata[28:0];
            if (pending_pixels.size() == 0) begin
                flag_mismatch($sformatf("unexpected result row %0d col %0d", got.row, got.col));
                return;
            end
            want = pending_pixels.pop_front();
            if (tdata[31:29] !== 3'b000)
                flag_mismatch($sformatf("tdata padding %b", tdata[31:29]));
            if (got.regular !== want.regular)
                flag_mismatch($sformatf("is_regular %b, want %b at row %0d col %0d",
                                        got.regular, want.regular, want.row, want.col));
            if (got.row !== want.row)
                flag_mismatch($sformatf("pixel_row %0d, want %0d", got.row, want.row));
            if (got.col !== want.col)
                flag_mismatch($sformatf("pixel_col %0d, want %0d", got.col, want.col));
        endtask
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic [31:0]       prdata;
    logic              pready;

    mask_checker sb = new();
    bit          quiet = 1'b0;
    longint      terrain = 0;

    dsm_regular_mask_3x3 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly smooth terrain around the current base, plus nodata, extremes and raw noise
    function automatic logic [31:0] make_elevation();
        int unsigned pick;
        longint      v;
        longint      span;
        longint      nd;
        nd   = longint'(sb.nodata_reg);
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0) terrain += longint'($urandom_range(0, 64)) - 32;
        if (pick < 65) begin
            span = $urandom_range(0, 1) ? 48 : 900;
            v = terrain + longint'($urandom_range(0, 2 * span)) - span;
        end else if (pick < 75) begin
            v = nd - longint'($urandom_range(0, 3));
        end else if (pick < 83) begin
            v = nd + longint'($urandom_range(0, 1));
        end else if (pick < 93) begin
            v = longint'($signed($urandom()));
        end else begin
            v = $urandom_range(0, 1) ? ELEV_LO : ELEV_HI;
        end
        if (v < ELEV_LO) v = ELEV_LO;
        if (v > ELEV_HI) v = ELEV_HI;
        return v[31:0];
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== sb.reg_value(idx))
            sb.flag_mismatch($sformatf("register %0d reads %h, want %h",
                                       idx, prdata, sb.reg_value(idx)));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_sample(input logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_sample(v);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] thr, input logic [31:0] nd,
                             input longint base, input int count,
                             input bit to_frame_end, input bit calm);
        quiet = calm;
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_THRESH, thr);
        write_reg(REG_NODATA, nd);
        terrain = base;
        repeat (count) send_sample(make_elevation());
        if (to_frame_end) begin
            while (!sb.frame_start()) send_sample(make_elevation());
        end
        settle();
    endtask

    // sink: ready high with random stalls, none while quiet
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata);
    end

    initial begin
        // centre at max with nodata neighbours, centre nodata, no valid neighbour
        logic [31:0] extreme_frame [15] = '{
            ELEV_MIN_P1, ELEV_MIN_P1, ELEV_MIN, ELEV_MIN, ELEV_MIN,
            ELEV_MIN_P1, ELEV_MAX,    ELEV_MIN, ELEV_MAX, ELEV_MIN,
            ELEV_MIN_P1, ELEV_MIN_P1, ELEV_MIN, ELEV_MIN, ELEV_MIN};
        logic [31:0] mixed_frame [9] = '{
            -32'sd50,  ELEV_MIN,  32'sd100,
            ELEV_MIN,  32'sd7,    32'sd300,
            ELEV_MIN,  32'sd200,  ELEV_MIN};
        longint base;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_WIDTH, 32'd5);
        write_reg(REG_HEIGHT, 32'd3);
        write_reg(REG_THRESH, 32'hFF_FFFF);
        write_reg(REG_NODATA, ELEV_MIN);
        foreach (extreme_frame[k]) send_sample(extreme_frame[k]);
        settle();
        write_reg(REG_WIDTH, 32'd3);
        foreach (mixed_frame[k]) send_sample(mixed_frame[k]);
        settle();

        run_phase(32'd3, 32'd3, 32'd0, RST_NODATA, 64'sd256000, 90, 1'b1, 1'b0);
        run_phase(32'd7, 32'd5, 32'd256, RST_NODATA, 64'sd25600, 350, 1'b1, 1'b0);
        run_phase(32'd0, 32'd2, 32'd64, ELEV_MIN, -64'sd1000000, 180, 1'b1, 1'b0);
        run_phase(32'd16, 32'd4, 32'hFF_FFFF, ELEV_MAX, 64'sd0, 64, 1'b1, 1'b0);
        base = longint'($urandom_range(0, 32'h3FFF_FFFF)) - 64'sh2000_0000;
        run_phase(32'd12, 32'd6, $urandom_range(0, 4095), base[31:0], base, 360, 1'b1, 1'b0);
        // stop mid-frame, then shrink both width and height under the counters
        run_phase(32'd10, 32'd65535, 32'd512, RST_NODATA, 64'sd51200, 57, 1'b0, 1'b0);
        run_phase(32'd6, 32'd3, 32'd300, RST_NODATA, 64'sd51200, 300, 1'b1, 1'b0);
        run_phase(32'd8191, 32'd3, 32'd256, RST_NODATA, 64'sd700000, 0, 1'b1, 1'b1);
        run_phase(32'd33, 32'd8, $urandom_range(100, 2000), RST_NODATA, -64'sd300000,
                  400, 1'b1, 1'b0);

        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
